>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the brightness and contrast block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks an implication property on every rising edge of aclk outside reset.
`define RBCA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Checks that a condition holds in the cycle after the antecedent.
`define RBCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBCA_ASSERT_IMPL(lbl, ante, cons, msg)
`define RBCA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/rbca_pkg.sv
// Package with widths, constants and shared types of the brightness and contrast block.
package rbca_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_LANES  = 3;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 16;
    localparam int TDATA_W    = NUM_LANES * CHAN_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

    // Constants of the contrast gain formula and the stretch center.
    localparam int GAIN_K_NUM = 259;
    localparam int GAIN_K_DEN = 255;
    localparam int CHAN_MAX   = 255;
    localparam int MID_GREY   = 128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = CFG_IDX_W'(1);

    // Per-stage load enables that the top level hands to every lane.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } rbca_pipe_ctl_t;

endpackage

>>> sv/rgb_brightness_contrast_adjust_top.sv
// Top level of the RGB brightness and contrast adjustment block.
//
// One item on the s_ channel is one RGB pixel; one item on the m_ channel is
// the adjusted pixel. Red, green and blue run through three identical lanes
// side by side, and the output stage merges their results into one item.
// Items move on tvalid and tready both high at a rising edge of aclk.
// m_tvalid rises once an accepted pixel has passed the lane stage registers
// (stage 1, stage 2, stage 3). The block takes one pixel per clock for as
// long as the receiver keeps m_tready high and no gain update is running.
// Each lane stage loads whenever it is empty or its successor moves on, so a
// stalled receiver first lets the empty stages fill and only then drops
// s_tready; no item is lost or repeated.
// The configuration channel writes brightness (index 0) or contrast (index 1);
// writes to other indexes are ignored. A contrast write above -255 starts a
// restoring division that computes the gain, one quotient bit per cycle;
// during that time both s_tready and cfg_ready are low.
// A synchronous low on aresetn empties the pipeline and sets brightness to
// zero and the gain to unity.
module rgb_brightness_contrast_adjust_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Input pixel, from the lowest bit: red_in, green_in, blue_in.
    input  logic [rbca_pkg::TDATA_W-1:0]          s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Output pixel, from the lowest bit: red_out, green_out, blue_out.
    output logic [rbca_pkg::TDATA_W-1:0]          m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rbca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rbca_pkg::CFG_W-1:0]            cfg_data
);
    import rbca_pkg::*;

    logic                      vld1_reg, vld1_next;
    logic                      vld2_reg, vld2_next;
    logic                      vld3_reg, vld3_next;
    logic signed [CFG_W-1:0]   brightness_reg, brightness_next;
    logic                      adv1, adv2, adv3;
    logic                      in_accept;
    logic                      cfg_accept;
    logic                      gain_start;
    logic                      gain_busy;
    logic [GAIN_W-1:0]         gain;
    rbca_pipe_ctl_t            ctl;
    logic [CHAN_W-1:0]         lane_out [NUM_LANES];

    // A stage may load when it is empty or its contents move on.
    assign adv3 = !vld3_reg || m_tready;
    assign adv2 = !vld2_reg || adv3;
    assign adv1 = !vld1_reg || adv2;

    assign s_tready  = adv1 && !gain_busy;
    assign in_accept = s_tvalid && s_tready;

    assign ctl.en1 = in_accept;
    assign ctl.en2 = adv2 && vld1_reg;
    assign ctl.en3 = adv3 && vld2_reg;

    assign vld1_next = adv1 ? in_accept : vld1_reg;
    assign vld2_next = adv2 ? vld1_reg  : vld2_reg;
    assign vld3_next = adv3 ? vld2_reg  : vld3_reg;

    assign cfg_ready  = !gain_busy;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign gain_start = cfg_accept && (cfg_index == REG_CONTRAST);
    assign brightness_next = (cfg_accept && (cfg_index == REG_BRIGHTNESS)) ?
                             $signed(cfg_data) : brightness_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg       <= 1'b0;
            vld2_reg       <= 1'b0;
            vld3_reg       <= 1'b0;
            brightness_reg <= '0;
        end else begin
            vld1_reg       <= vld1_next;
            vld2_reg       <= vld2_next;
            vld3_reg       <= vld3_next;
            brightness_reg <= brightness_next;
        end
    end

    rbca_gain_div u_gain_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gain_start),
        .level   ($signed(cfg_data)),
        .busy    (gain_busy),
        .gain    (gain)
    );

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        rbca_lane u_lane (
            .aclk       (aclk),
            .ctl        (ctl),
            .brightness (brightness_reg),
            .gain       (gain),
            .chan_in    (s_tdata[i*CHAN_W +: CHAN_W]),
            .chan_out   (lane_out[i])
        );
    end

    // Merge the lane results into one output item.
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            m_tdata[i*CHAN_W +: CHAN_W] = lane_out[i];
        end
    end

    assign m_tvalid = vld3_reg;

`include "assert_macros.svh"

    // Contrast levels of -255 and below give zero gain at once, without a division.
    `RBCA_ASSERT_IMPL(a_no_input_while_div, in_accept, !gain_busy, "pixel taken during gain update")
    `RBCA_ASSERT_NEXT(a_contrast_starts_div, gain_start && ($signed(cfg_data) > -9'sd255), gain_busy, "contrast write did not start divider")
    `RBCA_ASSERT_NEXT(a_out_held_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output changed")
    `RBCA_ASSERT_IMPL(a_empty_pipe_ready, !vld1_reg && !vld2_reg && !vld3_reg && !gain_busy, s_tready, "empty pipeline refused input")

endmodule

>>> sv/rbca_gain_div.sv
// Restoring divider that derives the Q8.16 contrast gain from a contrast level.
module rbca_gain_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [rbca_pkg::CFG_W-1:0]   level,
    output logic                                busy,
    output logic        [rbca_pkg::GAIN_W-1:0]  gain
);
    import rbca_pkg::*;

    localparam int NUM_W = 18;
    localparam int DEN_W = 18;
    localparam int DVD_W = NUM_W + GAIN_FRAC;
    localparam int CNT_W = $clog2(DVD_W + 1);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                    state_reg, state_next;
    logic [DVD_W-1:0]          dq_reg, dq_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [GAIN_W-1:0]         gain_reg, gain_next;

    logic signed [CFG_W:0]     lvl_plus;
    logic signed [CFG_W+1:0]   lvl_minus;
    logic [NUM_W-1:0]          num;
    logic [DEN_W-1:0]          den;
    logic [DEN_W:0]            shifted;
    logic                      fits;
    logic [DVD_W-1:0]          quo_full;

    // Numerator 259*(c+255) and denominator 255*(259-c), both constant multiplies.
    assign lvl_plus  = (CFG_W+1)'(level) + (CFG_W+1)'(CHAN_MAX);
    assign lvl_minus = (CFG_W+2)'(GAIN_K_NUM) - (CFG_W+2)'(level);
    assign num = NUM_W'(lvl_plus[CFG_W-1:0]) * NUM_W'(GAIN_K_NUM);
    assign den = DEN_W'(lvl_minus[CFG_W:0]) * DEN_W'(GAIN_K_DEN);

    assign shifted  = {rem_reg, dq_reg[DVD_W-1]};
    assign fits     = shifted >= {1'b0, den_reg};
    assign quo_full = {dq_reg[DVD_W-2:0], fits};

    always_comb begin
        state_next = state_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        gain_next  = gain_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (lvl_plus <= 0) begin
                        // Gain is zero or negative: it saturates to zero.
                        gain_next = '0;
                    end else begin
                        dq_next    = {num, GAIN_FRAC'(0)};
                        rem_next   = '0;
                        den_next   = den;
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                rem_next = fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
                dq_next  = quo_full;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    gain_next  = (|quo_full[DVD_W-1:GAIN_W]) ? '1 : quo_full[GAIN_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gain_reg  <= GAIN_ONE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            gain_reg  <= gain_next;
            cnt_reg   <= cnt_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = (state_reg == ST_RUN);
    assign gain = gain_reg;

endmodule

>>> sv/rbca_lane.sv
// Three-stage datapath that adjusts one color channel.
module rbca_lane (
    input  logic                                 aclk,
    input  rbca_pkg::rbca_pipe_ctl_t             ctl,
    input  logic signed [rbca_pkg::CFG_W-1:0]    brightness,
    input  logic        [rbca_pkg::GAIN_W-1:0]   gain,
    input  logic        [rbca_pkg::CHAN_W-1:0]   chan_in,
    output logic        [rbca_pkg::CHAN_W-1:0]   chan_out
);
    import rbca_pkg::*;

    localparam int SUM_W  = CFG_W + 1;
    localparam int PROD_W = GAIN_W + 1 + CHAN_W;
    localparam int Q_W    = PROD_W - GAIN_FRAC;

    logic signed [SUM_W-1:0]   sum;
    logic        [CHAN_W-1:0]  bright_v;
    logic signed [CHAN_W-1:0]  dev_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [Q_W-1:0]     quot;
    logic signed [Q_W:0]       shifted_back;
    logic        [CHAN_W-1:0]  out_reg;

    // First clamp after the brightness offset.
    assign sum = $signed({2'b00, chan_in}) + SUM_W'(brightness);
    always_comb begin
        if (sum < 0) begin
            bright_v = '0;
        end else if (sum > SUM_W'(CHAN_MAX)) begin
            bright_v = CHAN_W'(CHAN_MAX);
        end else begin
            bright_v = sum[CHAN_W-1:0];
        end
    end

    // The arithmetic shift floors the signed product, matching the rounding rule.
    assign quot         = prod_reg[PROD_W-1:GAIN_FRAC];
    assign shifted_back = (Q_W+1)'(quot) + (Q_W+1)'(MID_GREY);

    always_ff @(posedge aclk) begin
        if (ctl.en1) begin
            // v - 128 is v with its top bit flipped, read as signed.
            dev_reg <= $signed({~bright_v[CHAN_W-1], bright_v[CHAN_W-2:0]});
        end
        if (ctl.en2) begin
            prod_reg <= $signed({1'b0, gain}) * dev_reg;
        end
        if (ctl.en3) begin
            if (shifted_back < 0) begin
                out_reg <= '0;
            end else if (shifted_back > (Q_W+1)'(CHAN_MAX)) begin
                out_reg <= CHAN_W'(CHAN_MAX);
            end else begin
                out_reg <= shifted_back[CHAN_W-1:0];
            end
        end
    end

    assign chan_out = out_reg;

endmodule
